>>> rtl/core/csit_pkg.sv
// ----------------------------------------------------------------------------
// csit_pkg
// Shared types and constants for the collider set intersection test.
// ----------------------------------------------------------------------------
package csit_pkg;

  localparam int MAX_COLLIDERS = 16;
  localparam int IDX_W         = $clog2(MAX_COLLIDERS);
  localparam int CNT_W         = $clog2(MAX_COLLIDERS + 1);
  localparam int PAIR_LAT      = 5;
  localparam int ROT_W         = $clog2(MAX_COLLIDERS + PAIR_LAT + 1);

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_STORE = 2'd1;
  localparam logic [1:0] MODE_TEST  = 2'd2;

  localparam logic KIND_SPHERE = 1'b0;
  localparam logic KIND_BOX    = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic        shape_kind;
    logic [31:0] coord_0;
    logic [31:0] coord_1;
    logic [31:0] coord_2;
    logic [31:0] coord_3;
    logic [31:0] coord_4;
    logic [31:0] coord_5;
    logic [31:0] offset_x;
    logic [31:0] offset_y;
    logic [31:0] offset_z;
    logic        last_item;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] hit_entry;
  } out_t;

  // one collider after the offset shift
  typedef struct packed {
    logic             kind;
    logic [5:0][31:0] c;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } pair_res_t;

endpackage

>>> rtl/core/csit_cell.sv
// ----------------------------------------------------------------------------
// csit_cell
// One stored collider slot of the rotating ring.
// ----------------------------------------------------------------------------
module csit_cell (
  input  logic              clk,
  input  logic              shift_en,
  input  csit_pkg::entry_t  shift_in,
  input  logic              load_en,
  input  csit_pkg::entry_t  load_data,
  output csit_pkg::entry_t  entry
);

  csit_pkg::entry_t entry_r;
  csit_pkg::entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (load_en) begin
      entry_nxt = load_data;
    end else if (shift_en) begin
      entry_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

>>> rtl/core/csit_pair.sv
// ----------------------------------------------------------------------------
// csit_pair
// Pipelined overlap test of one stored collider against the test collider.
// ----------------------------------------------------------------------------
module csit_pair (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [csit_pkg::IDX_W-1:0]  in_idx,
  input  csit_pkg::entry_t            stored,
  input  csit_pkg::entry_t            probe,
  output csit_pkg::pair_res_t         res
);

  // ---------------- stage 1: geometry ----------------
  logic signed [33:0] ss_r;
  logic signed [32:0] ss_d [3];
  logic signed [32:0] sb_d [3];
  logic signed [31:0] lo_v, hi_v, p_v, q_v;
  logic signed [31:0] alo, ahi, blo, bhi;
  logic               sb_in;
  logic               bb_hit;
  csit_pkg::entry_t   sph, bx;
  logic signed [33:0] r_sel;
  logic signed [32:0] d_sel [3];
  logic [32:0]        m_c [4];

  always_comb begin
    sph = (stored.kind == csit_pkg::KIND_SPHERE) ? stored : probe;
    bx  = (stored.kind == csit_pkg::KIND_SPHERE) ? probe : stored;
    ss_r = 34'(signed'(stored.c[3])) + 34'(signed'(probe.c[3]));
    sb_in  = 1'b1;
    bb_hit = 1'b1;
    for (int k = 0; k < 3; k++) begin
      ss_d[k] = 33'(signed'(probe.c[k])) - 33'(signed'(stored.c[k]));
      lo_v = (signed'(bx.c[k]) < signed'(bx.c[k+3])) ? bx.c[k] : bx.c[k+3];
      hi_v = (signed'(bx.c[k]) < signed'(bx.c[k+3])) ? bx.c[k+3] : bx.c[k];
      p_v  = sph.c[k];
      q_v  = p_v;
      if (p_v < lo_v) begin
        q_v   = lo_v;
        sb_in = 1'b0;
      end
      if (p_v > hi_v) begin
        q_v   = hi_v;
        sb_in = 1'b0;
      end
      sb_d[k] = 33'(q_v) - 33'(p_v);
      alo = (signed'(stored.c[k]) < signed'(stored.c[k+3])) ? stored.c[k] : stored.c[k+3];
      ahi = (signed'(stored.c[k]) < signed'(stored.c[k+3])) ? stored.c[k+3] : stored.c[k];
      blo = (signed'(probe.c[k]) < signed'(probe.c[k+3])) ? probe.c[k] : probe.c[k+3];
      bhi = (signed'(probe.c[k]) < signed'(probe.c[k+3])) ? probe.c[k+3] : probe.c[k];
      if (ahi < blo || alo > bhi) begin
        bb_hit = 1'b0;
      end
    end
    if (stored.kind == csit_pkg::KIND_SPHERE && probe.kind == csit_pkg::KIND_SPHERE) begin
      r_sel = ss_r;
      for (int k = 0; k < 3; k++) d_sel[k] = ss_d[k];
    end else begin
      r_sel = 34'(signed'(sph.c[3]));
      for (int k = 0; k < 3; k++) d_sel[k] = sb_d[k];
    end
    // magnitudes stay below 2^33; a negative radius is flagged separately
    m_c[0] = r_sel[32:0];
    for (int k = 0; k < 3; k++) begin
      m_c[k+1] = d_sel[k][32] ? 33'(-d_sel[k]) : 33'(d_sel[k]);
    end
  end

  logic                       v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [csit_pkg::IDX_W-1:0] i1_r, i2_r, i3_r, i4_r, i5_r;
  logic                       bb1_r, bb2_r, bb3_r, bb4_r;
  logic                       bh1_r, bh2_r, bh3_r, bh4_r;
  logic                       in1_r, in2_r, in3_r, in4_r;
  logic                       rn1_r, rn2_r, rn3_r, rn4_r;
  logic                       h5_r;
  logic [32:0]                m1_r [4];
  logic [63:0]                ll2_r [4];
  logic [32:0]                m2_r [4];
  logic [67:0]                sq3_r [4];
  logic [67:0]                rr4_r, ds4_r;
  logic                       both_box;

  assign both_box = (stored.kind == csit_pkg::KIND_BOX) && (probe.kind == csit_pkg::KIND_BOX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1
    i1_r  <= in_idx;
    bb1_r <= both_box;
    bh1_r <= bb_hit;
    in1_r <= sb_in && !(stored.kind == csit_pkg::KIND_SPHERE &&
                        probe.kind == csit_pkg::KIND_SPHERE);
    rn1_r <= r_sel[33];
    for (int k = 0; k < 4; k++) m1_r[k] <= m_c[k];
    // stage 2: low-half products
    i2_r <= i1_r; bb2_r <= bb1_r; bh2_r <= bh1_r; in2_r <= in1_r; rn2_r <= rn1_r;
    for (int k = 0; k < 4; k++) begin
      ll2_r[k] <= m1_r[k][31:0] * m1_r[k][31:0];
      m2_r[k]  <= m1_r[k];
    end
    // stage 3: exact squares, (h*2^32 + l)^2 with h one bit
    i3_r <= i2_r; bb3_r <= bb2_r; bh3_r <= bh2_r; in3_r <= in2_r; rn3_r <= rn2_r;
    for (int k = 0; k < 4; k++) begin
      sq3_r[k] <= 68'(ll2_r[k])
                + (m2_r[k][32] ? ({3'b0, m2_r[k][31:0], 33'b0} + (68'd1 << 64)) : 68'd0);
    end
    // stage 4: distance sum
    i4_r <= i3_r; bb4_r <= bb3_r; bh4_r <= bh3_r; in4_r <= in3_r; rn4_r <= rn3_r;
    rr4_r <= sq3_r[0];
    ds4_r <= sq3_r[1] + sq3_r[2] + sq3_r[3];
    // stage 5: decision
    i5_r <= i4_r;
    h5_r <= bb4_r ? bh4_r : (in4_r || (!rn4_r && rr4_r >= ds4_r));
  end

  assign res.valid = v5_r;
  assign res.hit   = h5_r;
  assign res.idx   = i5_r;

endmodule

>>> rtl/core/collider_set_intersection_test_top.sv
// ----------------------------------------------------------------------------
// collider_set_intersection_test_top
// Stores one body's colliders in a ring of cells and tests colliders of a
// second body against them, reporting any hit and the lowest entry hit.
// ----------------------------------------------------------------------------
//  channel  ports                  handshake
//  input    in_item                start & !busy
//  result   out_valid, out_word    out_valid, one cycle, no back-pressure
//
//  Clear and store leave busy low.
//  A test holds busy while the ring rotates one entry a cycle through the pair
//  pipeline, then drains it.
//  A test marked last drives its word in the first cycle with busy low.
//  rst_n is synchronous; it empties the set and clears the hit tracking.
// ----------------------------------------------------------------------------
module collider_set_intersection_test_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  csit_pkg::in_t   in_item,
  output logic            out_valid,
  output csit_pkg::out_t  out_word
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                        state_r, state_nxt;
  logic [csit_pkg::ROT_W-1:0]  rot_r, rot_nxt;
  logic [csit_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                        run_hit_r, run_hit_nxt;
  logic [csit_pkg::IDX_W-1:0]  first_r, first_nxt;
  logic                        last_r;
  logic                        out_valid_r, out_valid_nxt;
  csit_pkg::out_t              out_word_r, out_word_nxt;
  csit_pkg::entry_t            probe_r;
  csit_pkg::entry_t            shifted;
  csit_pkg::entry_t            cells [csit_pkg::MAX_COLLIDERS];
  csit_pkg::pair_res_t         pres;
  logic                        accept, rotate, issue, finish, do_store;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r == ST_RUN);
  assign rotate   = (state_r == ST_RUN) &&
                    (rot_r < csit_pkg::ROT_W'(csit_pkg::MAX_COLLIDERS));
  assign issue    = rotate && (csit_pkg::CNT_W'(rot_r) < count_r);
  assign finish   = (state_r == ST_RUN) &&
                    (rot_r == csit_pkg::ROT_W'(csit_pkg::MAX_COLLIDERS + csit_pkg::PAIR_LAT));
  assign do_store = accept && (in_item.mode == csit_pkg::MODE_STORE) &&
                    (count_r < csit_pkg::CNT_W'(csit_pkg::MAX_COLLIDERS));

  // offset shift; box corners both move, sphere radius does not
  always_comb begin
    shifted.kind = in_item.shape_kind;
    shifted.c[0] = in_item.coord_0 + in_item.offset_x;
    shifted.c[1] = in_item.coord_1 + in_item.offset_y;
    shifted.c[2] = in_item.coord_2 + in_item.offset_z;
    shifted.c[3] = in_item.coord_3;
    shifted.c[4] = in_item.coord_4;
    shifted.c[5] = in_item.coord_5;
    if (in_item.shape_kind == csit_pkg::KIND_BOX) begin
      shifted.c[3] = in_item.coord_3 + in_item.offset_x;
      shifted.c[4] = in_item.coord_4 + in_item.offset_y;
      shifted.c[5] = in_item.coord_5 + in_item.offset_z;
    end
  end

  // ring of entries; cell 0 feeds the pair unit, a full turn restores order
  for (genvar i = 0; i < csit_pkg::MAX_COLLIDERS; i++) begin : g_cell
    csit_cell u_cell (
      .clk       (clk),
      .shift_en  (rotate),
      .shift_in  (cells[(i + 1) % csit_pkg::MAX_COLLIDERS]),
      .load_en   (do_store && (count_r == csit_pkg::CNT_W'(i))),
      .load_data (shifted),
      .entry     (cells[i])
    );
  end

  csit_pair u_pair (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (issue),
    .in_idx   (rot_r[csit_pkg::IDX_W-1:0]),
    .stored   (cells[0]),
    .probe    (probe_r),
    .res      (pres)
  );

  always_comb begin
    state_nxt     = state_r;
    rot_nxt       = rot_r;
    count_nxt     = count_r;
    run_hit_nxt   = run_hit_r;
    first_nxt     = first_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    if (pres.valid && pres.hit) begin
      if (!run_hit_r || pres.idx < first_r) first_nxt = pres.idx;
      run_hit_nxt = 1'b1;
    end
    if (finish) begin
      state_nxt = ST_IDLE;
      if (last_r) begin
        out_valid_nxt          = 1'b1;
        out_word_nxt.hit       = run_hit_r;
        out_word_nxt.hit_entry = run_hit_r ? 4'(first_r) : 4'd0;
        run_hit_nxt            = 1'b0;
        first_nxt              = '0;
      end
    end else if (state_r == ST_RUN) begin
      rot_nxt = rot_r + 1'b1;
    end
    if (accept) begin
      case (in_item.mode)
        csit_pkg::MODE_CLEAR: begin
          count_nxt   = '0;
          run_hit_nxt = 1'b0;
          first_nxt   = '0;
        end
        csit_pkg::MODE_STORE: begin
          if (do_store) count_nxt = count_r + 1'b1;
        end
        csit_pkg::MODE_TEST: begin
          state_nxt = ST_RUN;
          rot_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rot_r       <= '0;
      count_r     <= '0;
      run_hit_r   <= 1'b0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rot_r       <= rot_nxt;
      count_r     <= count_nxt;
      run_hit_r   <= run_hit_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (accept && in_item.mode == csit_pkg::MODE_TEST) begin
      probe_r <= shifted;
      last_r  <= in_item.last_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
